// ===== design/accel_stillness_detector_assert.svh =====
// Assertion macros shared by the stillness detector modules.
// Each expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ACCEL_STILLNESS_DETECTOR_ASSERT_SVH
`define ACCEL_STILLNESS_DETECTOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/asd_pkg.sv =====
// Shared types and constants for the accelerometer stillness detector.
// Used by asd_ctrl, asd_datapath and accel_stillness_detector; no dependencies.
package asd_pkg;

    // Field and register widths.
    localparam int ACCEL_W   = 16;
    localparam int ABS_W     = ACCEL_W + 1;
    localparam int CFG_W     = 24;
    localparam int HOLD_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int LEVEL_W   = 25;

    // Arithmetic widths.
    localparam int MUL_A_W  = 25;
    localparam int MUL_B_W  = 24;
    localparam int PROD_W   = 50;
    localparam int ACC_W    = 51;
    localparam int SUMSQ_W  = 32;
    localparam int RAD_W    = 48;
    localparam int ROOT_W   = 24;
    localparam int SQREM_W  = 26;
    localparam int DIVQ_W   = 25;
    localparam int DIVD_W   = 50;
    localparam int DEN_W    = 25;
    localparam int CNT_W    = 5;

    // Last step index of each iterative loop.
    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIVQ_W - 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAU       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 3'd3;

    // Configuration reset values.
    localparam logic [CFG_W-1:0]  BIAS_RESET      = 24'd251136;
    localparam logic [CFG_W-1:0]  TAU_RESET       = 24'd31831;
    localparam logic [CFG_W-1:0]  THRESHOLD_RESET = 24'd768;
    localparam logic [HOLD_W-1:0] HOLD_RESET      = 16'd200;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_ROOT_INIT,
        ST_ROOT,
        ST_DIFF,
        ST_MUL_IN,
        ST_SUM,
        ST_DIV_INIT,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        MUL_SQ_X,
        MUL_SQ_Y,
        MUL_SQ_Z,
        MUL_FILT,
        MUL_INPUT
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        logic     load_in;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     root_init;
        logic     root_step;
        logic     diff_load;
        logic     div_init;
        logic     div_step;
        logic     finish;
    } dp_cmd_t;

    typedef struct packed {
        logic out_stall;
    } dp_status_t;

endpackage

// ===== design/asd_ctrl.sv =====
// Sequencer for the stillness detector: steps one request through the datapath.
// Depends on asd_pkg and accel_stillness_detector_assert.svh.
`include "accel_stillness_detector_assert.svh"

module asd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  asd_pkg::dp_status_t status,
    output asd_pkg::dp_cmd_t    cmd
);

    asd_pkg::state_t                state_reg;
    asd_pkg::state_t                state_next;
    logic [asd_pkg::CNT_W-1:0]      cnt_reg;
    logic [asd_pkg::CNT_W-1:0]      cnt_next;

    // State and step counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= asd_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = '0;
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.mul_sel   = asd_pkg::MUL_SQ_X;
        cmd.acc_op    = asd_pkg::ACC_HOLD;
        case (state_reg)
            asd_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                if (in_valid)
                begin
                    state_next = asd_pkg::ST_SQ_X;
                end
            end
            asd_pkg::ST_SQ_X:
            begin
                cmd.mul_sel = asd_pkg::MUL_SQ_X;
                state_next  = asd_pkg::ST_SQ_Y;
            end
            asd_pkg::ST_SQ_Y:
            begin
                cmd.mul_sel = asd_pkg::MUL_SQ_Y;
                cmd.acc_op  = asd_pkg::ACC_LOAD;
                state_next  = asd_pkg::ST_SQ_Z;
            end
            asd_pkg::ST_SQ_Z:
            begin
                cmd.mul_sel = asd_pkg::MUL_SQ_Z;
                cmd.acc_op  = asd_pkg::ACC_ADD;
                state_next  = asd_pkg::ST_ROOT_INIT;
            end
            asd_pkg::ST_ROOT_INIT:
            begin
                cmd.root_init = 1'b1;
                state_next    = asd_pkg::ST_ROOT;
            end
            asd_pkg::ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (cnt_reg == asd_pkg::ROOT_LAST)
                begin
                    state_next = asd_pkg::ST_DIFF;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            asd_pkg::ST_DIFF:
            begin
                // The old filter value times tau runs alongside the bias removal.
                cmd.diff_load = 1'b1;
                cmd.mul_sel   = asd_pkg::MUL_FILT;
                state_next    = asd_pkg::ST_MUL_IN;
            end
            asd_pkg::ST_MUL_IN:
            begin
                cmd.mul_sel = asd_pkg::MUL_INPUT;
                cmd.acc_op  = asd_pkg::ACC_LOAD;
                state_next  = asd_pkg::ST_SUM;
            end
            asd_pkg::ST_SUM:
            begin
                cmd.acc_op = asd_pkg::ACC_ADD;
                state_next = asd_pkg::ST_DIV_INIT;
            end
            asd_pkg::ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = asd_pkg::ST_DIV;
            end
            asd_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == asd_pkg::DIV_LAST)
                begin
                    state_next = asd_pkg::ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            asd_pkg::ST_FINISH:
            begin
                // Hold the update until the previous result has been taken.
                if (!status.out_stall)
                begin
                    cmd.finish = 1'b1;
                    state_next = asd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = asd_pkg::ST_IDLE;
            end
        endcase
    end

    `ASD_ASSERT_IMPL(a_finish_not_stalled, cmd.finish, !status.out_stall, "finish while output stalled")
    `ASD_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_reg == asd_pkg::ST_SQ_X, "accepted request did not start")
    `ASD_ASSERT_IMPL(a_div_count_range, state_reg == asd_pkg::ST_DIV, cnt_reg <= asd_pkg::DIV_LAST, "divider step count overrun")

endmodule

// ===== design/asd_datapath.sv =====
// Datapath of the stillness detector: config registers, shared multiplier,
// bit-serial square root and divider, filter and stillness state.
// Depends on asd_pkg and accel_stillness_detector_assert.svh.
`include "accel_stillness_detector_assert.svh"

module asd_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [asd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [asd_pkg::CFG_W-1:0]           cfg_data,
    input  logic signed [asd_pkg::ACCEL_W-1:0]  accel_x,
    input  logic signed [asd_pkg::ACCEL_W-1:0]  accel_y,
    input  logic signed [asd_pkg::ACCEL_W-1:0]  accel_z,
    input  logic [asd_pkg::CFG_W-1:0]           elapsed_us,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic                                stopped,
    output logic                                still_now,
    output logic signed [asd_pkg::LEVEL_W-1:0]  filtered_level,
    input  asd_pkg::dp_cmd_t                    cmd,
    output asd_pkg::dp_status_t                 status
);

    // Configuration registers.
    logic [asd_pkg::CFG_W-1:0]  bias_reg;
    logic [asd_pkg::CFG_W-1:0]  tau_reg;
    logic [asd_pkg::CFG_W-1:0]  thresh_reg;
    logic [asd_pkg::HOLD_W-1:0] hold_reg;

    // Captured request.
    logic [asd_pkg::ABS_W-1:0]  ax_reg;
    logic [asd_pkg::ABS_W-1:0]  ay_reg;
    logic [asd_pkg::ABS_W-1:0]  az_reg;
    logic [asd_pkg::CFG_W-1:0]  dt_reg;

    // Multiplier and accumulator.
    logic signed [asd_pkg::PROD_W-1:0] prod_reg;
    logic signed [asd_pkg::ACC_W-1:0]  acc_reg;

    // Square root.
    logic [asd_pkg::RAD_W-1:0]   rad_reg;
    logic [asd_pkg::SQREM_W-1:0] sqrem_reg;
    logic [asd_pkg::ROOT_W-1:0]  root_reg;

    // Bias-removed magnitude and divider.
    logic signed [asd_pkg::LEVEL_W-1:0] diff_reg;
    logic                               neg_reg;
    logic [asd_pkg::DEN_W-1:0]          den_reg;
    logic [asd_pkg::DEN_W-1:0]          drem_reg;
    logic [asd_pkg::DIVQ_W-1:0]         dq_reg;

    // Filter and stillness state, which also drives the result.
    logic signed [asd_pkg::LEVEL_W-1:0] fv_reg;
    logic [asd_pkg::HOLD_W-1:0]         scnt_reg;
    logic                               still_reg;
    logic                               stopped_reg;
    logic                               out_valid_reg;

    // Combinational helpers.
    logic [asd_pkg::ABS_W-1:0]          ax_abs;
    logic [asd_pkg::ABS_W-1:0]          ay_abs;
    logic [asd_pkg::ABS_W-1:0]          az_abs;
    logic [asd_pkg::CFG_W-1:0]          tau_eff;
    logic signed [asd_pkg::MUL_A_W-1:0] mul_a;
    logic [asd_pkg::MUL_B_W-1:0]        mul_b;
    logic signed [asd_pkg::PROD_W-1:0]  prod;
    logic signed [asd_pkg::ACC_W-1:0]   prod_ext;
    logic [asd_pkg::SUMSQ_W-1:0]        sumsq;
    logic [asd_pkg::SQREM_W+1:0]        sq_shift;
    logic [asd_pkg::SQREM_W+1:0]        sq_trial;
    logic                               sq_ge;
    logic [asd_pkg::ACC_W-1:0]          num_mag;
    logic [asd_pkg::DEN_W-1:0]          den;
    logic [asd_pkg::DIVD_W-1:0]         dividend;
    logic [asd_pkg::DEN_W:0]            div_shift;
    logic                               div_ge;
    logic signed [asd_pkg::LEVEL_W-1:0] lvl;
    logic [asd_pkg::LEVEL_W-1:0]        lvl_abs;
    logic                               still_new;

    // Absolute values of the axes; the square only needs the magnitude.
    assign ax_abs = accel_x[asd_pkg::ACCEL_W-1] ? (asd_pkg::ABS_W'(0) - {1'b1, accel_x})
                                               : {1'b0, accel_x};
    assign ay_abs = accel_y[asd_pkg::ACCEL_W-1] ? (asd_pkg::ABS_W'(0) - {1'b1, accel_y})
                                               : {1'b0, accel_y};
    assign az_abs = accel_z[asd_pkg::ACCEL_W-1] ? (asd_pkg::ABS_W'(0) - {1'b1, accel_z})
                                               : {1'b0, accel_z};

    // A zero time constant acts as one.
    assign tau_eff = (tau_reg == '0) ? asd_pkg::CFG_W'(1) : tau_reg;

    // Shared multiplier operand selection.
    always_comb
    begin
        case (cmd.mul_sel)
            asd_pkg::MUL_SQ_X:
            begin
                mul_a = $signed(asd_pkg::MUL_A_W'(ax_reg));
                mul_b = asd_pkg::MUL_B_W'(ax_reg);
            end
            asd_pkg::MUL_SQ_Y:
            begin
                mul_a = $signed(asd_pkg::MUL_A_W'(ay_reg));
                mul_b = asd_pkg::MUL_B_W'(ay_reg);
            end
            asd_pkg::MUL_SQ_Z:
            begin
                mul_a = $signed(asd_pkg::MUL_A_W'(az_reg));
                mul_b = asd_pkg::MUL_B_W'(az_reg);
            end
            asd_pkg::MUL_FILT:
            begin
                mul_a = fv_reg;
                mul_b = tau_eff;
            end
            asd_pkg::MUL_INPUT:
            begin
                mul_a = diff_reg;
                mul_b = dt_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod     = mul_a * $signed({1'b0, mul_b});
    assign prod_ext = {prod_reg[asd_pkg::PROD_W-1], prod_reg};

    // Sum of squares is below 2^32, so the low words add without overflow.
    assign sumsq = acc_reg[asd_pkg::SUMSQ_W-1:0] + prod_reg[asd_pkg::SUMSQ_W-1:0];

    // One result bit of the square root per step.
    assign sq_shift = {sqrem_reg, rad_reg[asd_pkg::RAD_W-1 -: 2]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_ge    = (sq_shift >= sq_trial);

    // Divider setup: magnitude of the numerator plus half the divisor.
    assign num_mag  = acc_reg[asd_pkg::ACC_W-1] ? (asd_pkg::ACC_W'(0) - acc_reg) : acc_reg;
    assign den      = {1'b0, tau_eff} + {1'b0, dt_reg};
    assign dividend = num_mag[asd_pkg::DIVD_W-1:0] + asd_pkg::DIVD_W'(den >> 1);

    // One quotient bit per step; the remainder always stays below the divisor.
    assign div_shift = {drem_reg, dq_reg[asd_pkg::DIVQ_W-1]};
    assign div_ge    = (div_shift >= {1'b0, den_reg});

    // Signed, saturated filter result and its stillness test.
    always_comb
    begin
        if (neg_reg)
        begin
            lvl = $signed(asd_pkg::LEVEL_W'(0) - dq_reg);
        end
        else if (dq_reg[asd_pkg::DIVQ_W-1])
        begin
            lvl = $signed({1'b0, {(asd_pkg::LEVEL_W-1){1'b1}}});
        end
        else
        begin
            lvl = $signed(dq_reg);
        end
        lvl_abs   = lvl[asd_pkg::LEVEL_W-1] ? (asd_pkg::LEVEL_W'(0) - lvl) : lvl;
        still_new = (lvl_abs < {1'b0, thresh_reg});
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg   <= asd_pkg::BIAS_RESET;
            tau_reg    <= asd_pkg::TAU_RESET;
            thresh_reg <= asd_pkg::THRESHOLD_RESET;
            hold_reg   <= asd_pkg::HOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                asd_pkg::CFG_BIAS:      bias_reg   <= cfg_data;
                asd_pkg::CFG_TAU:       tau_reg    <= cfg_data;
                asd_pkg::CFG_THRESHOLD: thresh_reg <= cfg_data;
                asd_pkg::CFG_HOLD:      hold_reg   <= cfg_data[asd_pkg::HOLD_W-1:0];
                default:                ;
            endcase
        end
    end

    // Arithmetic payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            ax_reg <= ax_abs;
            ay_reg <= ay_abs;
            az_reg <= az_abs;
            dt_reg <= elapsed_us;
        end

        prod_reg <= prod;

        case (cmd.acc_op)
            asd_pkg::ACC_LOAD: acc_reg <= prod_ext;
            asd_pkg::ACC_ADD:  acc_reg <= acc_reg + prod_ext;
            default:           ;
        endcase

        if (cmd.root_init)
        begin
            rad_reg   <= {sumsq, {(asd_pkg::RAD_W-asd_pkg::SUMSQ_W){1'b0}}};
            sqrem_reg <= '0;
            root_reg  <= '0;
        end
        else if (cmd.root_step)
        begin
            rad_reg   <= {rad_reg[asd_pkg::RAD_W-3:0], 2'b00};
            sqrem_reg <= sq_ge ? asd_pkg::SQREM_W'(sq_shift - sq_trial)
                               : sq_shift[asd_pkg::SQREM_W-1:0];
            root_reg  <= {root_reg[asd_pkg::ROOT_W-2:0], sq_ge};
        end

        if (cmd.diff_load)
        begin
            diff_reg <= $signed({1'b0, root_reg}) - $signed({1'b0, bias_reg});
        end

        if (cmd.div_init)
        begin
            neg_reg  <= acc_reg[asd_pkg::ACC_W-1];
            den_reg  <= den;
            drem_reg <= dividend[asd_pkg::DIVD_W-1 -: asd_pkg::DEN_W];
            dq_reg   <= dividend[asd_pkg::DIVQ_W-1:0];
        end
        else if (cmd.div_step)
        begin
            drem_reg <= div_ge ? asd_pkg::DEN_W'(div_shift - {1'b0, den_reg})
                               : div_shift[asd_pkg::DEN_W-1:0];
            dq_reg   <= {dq_reg[asd_pkg::DIVQ_W-2:0], div_ge};
        end
    end

    // Filter state, still counter and stopped qualification.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg      <= '0;
            scnt_reg    <= '0;
            still_reg   <= 1'b1;
            stopped_reg <= 1'b1;
        end
        else if (cmd.finish)
        begin
            fv_reg    <= lvl;
            still_reg <= still_new;
            if (!still_new)
            begin
                stopped_reg <= 1'b0;
            end
            else if (scnt_reg > hold_reg)
            begin
                stopped_reg <= 1'b1;
                scnt_reg    <= asd_pkg::HOLD_W'(1);
            end
            else
            begin
                scnt_reg <= scnt_reg + 1'b1;
            end
        end
    end

    // Output valid: set on finish, cleared when the result is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign stopped          = stopped_reg;
    assign still_now        = still_reg;
    assign filtered_level   = fv_reg;
    assign status.out_stall = out_valid_reg && !out_ready;

    `ASD_ASSERT_IMPL(a_valid_from_finish, $rose(out_valid_reg), $past(cmd.finish), "result valid without finish")
    `ASD_ASSERT_IMPL(a_stopped_needs_still, out_valid_reg, !stopped_reg || still_reg, "stopped on a moving sample")

endmodule

// ===== design/accel_stillness_detector.sv =====
// Top level of the accelerometer stillness detector.
// Depends on asd_pkg, asd_ctrl and asd_datapath.
//
//   Channel   Direction  Handshake            Payload
//   in        sink       in_valid/in_ready    accel_x, accel_y, accel_z, elapsed_us
//   out       source     out_valid/out_ready  stopped, still_now, filtered_level
//   cfg       sink       cfg_we               cfg_index, cfg_data
//
// With the output drained, a request runs from acceptance through squaring, a root
// setup, 24 square-root steps, the filter products and divider setup, 25 divider
// steps and the update, then returns to idle, where the next request is accepted.
// The square-root and divider loops resolve one bit per cycle.
// Reset restores the default registers and the stopped, still state.
// A stalled output holds the last result; the next request is accepted meanwhile
// and waits at its update cycle until that result is taken.
module accel_stillness_detector (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [asd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [asd_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [asd_pkg::ACCEL_W-1:0]  accel_x,
    input  logic signed [asd_pkg::ACCEL_W-1:0]  accel_y,
    input  logic signed [asd_pkg::ACCEL_W-1:0]  accel_z,
    input  logic [asd_pkg::CFG_W-1:0]           elapsed_us,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                stopped,
    output logic                                still_now,
    output logic signed [asd_pkg::LEVEL_W-1:0]  filtered_level
);

    asd_pkg::dp_cmd_t    cmd;
    asd_pkg::dp_status_t status;

    // Sequencer.
    asd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic and state.
    asd_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .accel_x        (accel_x),
        .accel_y        (accel_y),
        .accel_z        (accel_z),
        .elapsed_us     (elapsed_us),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .stopped        (stopped),
        .still_now      (still_now),
        .filtered_level (filtered_level),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

// ===== bench/stillness_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the accelerometer stillness detector: it mirrors register writes,
// predicts one result per accepted request and compares it with the result channel.
// Depends on asd_pkg for widths, register indexes and reset values.
module stillness_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [asd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [asd_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic signed [asd_pkg::ACCEL_W-1:0]  accel_x,
    input  logic signed [asd_pkg::ACCEL_W-1:0]  accel_y,
    input  logic signed [asd_pkg::ACCEL_W-1:0]  accel_z,
    input  logic [asd_pkg::CFG_W-1:0]           elapsed_us,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                stopped,
    input  logic                                still_now,
    input  logic signed [asd_pkg::LEVEL_W-1:0]  filtered_level,
    output int                                  failures,
    output int                                  outstanding,
    output int                                  checked
);
    import asd_pkg::*;

    localparam longint LEVEL_TOP   = 2**(LEVEL_W-1) - 1;
    localparam longint LEVEL_FLOOR = -(2**(LEVEL_W-1));
    localparam int     SHOWN_MAX   = 10;

    typedef struct {
        logic                      stopped;
        logic                      still;
        logic signed [LEVEL_W-1:0] level;
    } level_result_t;

    // Results predicted for accepted requests, oldest first.
    level_result_t pending_levels[$];

    // Mirrored registers.
    logic [CFG_W-1:0]  bias_reg;
    logic [CFG_W-1:0]  tau_reg;
    logic [CFG_W-1:0]  thresh_reg;
    logic [HOLD_W-1:0] hold_reg;

    // Mirrored filter and qualification state.
    logic signed [LEVEL_W-1:0] filt_state;
    logic [HOLD_W-1:0]         still_run;
    logic                      still_state;
    logic                      stopped_state;

    level_result_t want;
    level_result_t got;
    int            shown = 0;

    // Bitwise integer square root, rounded down.
    function automatic longint unsigned floor_root(input longint unsigned radicand);
        longint unsigned rest;
        longint unsigned root;
        longint unsigned probe;
        rest  = radicand;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > rest)
            probe >>= 2;
        while (probe != 0)
        begin
            if (rest >= root + probe)
            begin
                rest = rest - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root >>= 1;
            probe >>= 2;
        end
        return root;
    endfunction

    // Advances the filter and the stillness logic by one sample.
    task automatic filter_sample(input logic signed [ACCEL_W-1:0] ax, ay, az,
                                 input logic [CFG_W-1:0] dt,
                                 output level_result_t r);
        longint sx;
        longint sy;
        longint sz;
        longint unsigned sumsq;
        longint mag;
        longint bias_i;
        longint tau_i;
        longint dt_i;
        longint thr_i;
        longint diff;
        longint num;
        longint den;
        longint qmag;
        longint lvl;
        longint alvl;
        sx = ax;
        sy = ay;
        sz = az;
        sumsq  = sx * sx + sy * sy + sz * sz;
        mag    = longint'(floor_root(sumsq << 16));
        bias_i = bias_reg;
        diff   = mag - bias_i;

        // A zero time constant behaves as one microsecond.
        tau_i = tau_reg;
        if (tau_i == 0)
            tau_i = 1;
        dt_i = dt;

        // Weighted mean, rounded to nearest with ties away from zero.
        num  = longint'(filt_state) * tau_i + diff * dt_i;
        den  = tau_i + dt_i;
        qmag = ((num < 0 ? -num : num) + den / 2) / den;
        lvl  = (num < 0) ? -qmag : qmag;
        if (lvl > LEVEL_TOP)
            lvl = LEVEL_TOP;
        if (lvl < LEVEL_FLOOR)
            lvl = LEVEL_FLOOR;
        filt_state = lvl[LEVEL_W-1:0];

        alvl  = (lvl < 0) ? -lvl : lvl;
        thr_i = thresh_reg;
        still_state = (alvl < thr_i);

        // Motion drops stopped at once; the run count survives motion.
        if (!still_state)
            stopped_state = 1'b0;
        else
        begin
            if (still_run > hold_reg)
            begin
                stopped_state = 1'b1;
                still_run     = '0;
            end
            still_run = still_run + 1'b1;
        end

        r.stopped = stopped_state;
        r.still   = still_state;
        r.level   = lvl[LEVEL_W-1:0];
    endtask

    // Register mirror, prediction on each request and comparison on each result.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg      = BIAS_RESET;
            tau_reg       = TAU_RESET;
            thresh_reg    = THRESHOLD_RESET;
            hold_reg      = HOLD_RESET;
            filt_state    = '0;
            still_run     = '0;
            still_state   = 1'b1;
            stopped_state = 1'b1;
            pending_levels.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BIAS:      bias_reg   = cfg_data;
                    CFG_TAU:       tau_reg    = cfg_data;
                    CFG_THRESHOLD: thresh_reg = cfg_data;
                    CFG_HOLD:      hold_reg   = cfg_data[HOLD_W-1:0];
                    default:       ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                got.stopped = stopped;
                got.still   = still_now;
                got.level   = filtered_level;
                if (pending_levels.size() == 0)
                begin
                    failures++;
                    if (shown < SHOWN_MAX)
                        $display("%0t: result with no request outstanding: stopped=%0b still=%0b level=%0d",
                                 $realtime, got.stopped, got.still, got.level);
                    shown++;
                end
                else
                begin
                    want = pending_levels.pop_front();
                    if (got.stopped !== want.stopped || got.still !== want.still ||
                        got.level !== want.level)
                    begin
                        failures++;
                        if (shown < SHOWN_MAX)
                            $display("%0t: result %0d expected stopped=%0b still=%0b level=%0d, got stopped=%0b still=%0b level=%0d",
                                     $realtime, checked, want.stopped, want.still, want.level,
                                     got.stopped, got.still, got.level);
                        shown++;
                    end
                end
                checked++;
            end

            if (in_valid && in_ready)
            begin
                filter_sample(accel_x, accel_y, accel_z, elapsed_us, want);
                pending_levels.push_back(want);
            end

            outstanding <= pending_levels.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Top of the stillness detector bench: clock, reset, request and register stimulus,
// result back-pressure and the verdict. Depends on asd_pkg, stillness_checker and the block.
module testbench;
    import asd_pkg::*;

    localparam int PHASES          = 9;
    localparam int STEADY_PHASE    = 1;
    localparam int SQUEEZE_PHASE   = 2;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_HOLD + 3'd1;

    typedef struct {
        logic signed [ACCEL_W-1:0] x;
        logic signed [ACCEL_W-1:0] y;
        logic signed [ACCEL_W-1:0] z;
        logic [CFG_W-1:0]          dt;
    } accel_sample_t;

    typedef struct {
        logic [CFG_W-1:0]  bias;
        logic [CFG_W-1:0]  tau;
        logic [CFG_W-1:0]  thresh;
        logic [HOLD_W-1:0] hold;
        int                items;
    } filter_setting_t;

    logic                       clk        = 1'b0;
    logic                       rst_n      = 1'b0;
    logic                       cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index  = '0;
    logic [CFG_W-1:0]           cfg_data   = '0;
    logic                       in_valid   = 1'b0;
    logic                       in_ready;
    logic signed [ACCEL_W-1:0]  accel_x    = '0;
    logic signed [ACCEL_W-1:0]  accel_y    = '0;
    logic signed [ACCEL_W-1:0]  accel_z    = '0;
    logic [CFG_W-1:0]           elapsed_us = '0;
    logic                       out_valid;
    logic                       out_ready  = 1'b0;
    logic                       stopped;
    logic                       still_now;
    logic signed [LEVEL_W-1:0]  filtered_level;

    int failures;
    int outstanding;
    int checked;
    int sent         = 0;
    bit steady       = 1'b0;
    bit hold_off_req = 1'b0;

    accel_stillness_detector dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .accel_x        (accel_x),
        .accel_y        (accel_y),
        .accel_z        (accel_z),
        .elapsed_us     (elapsed_us),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .stopped        (stopped),
        .still_now      (still_now),
        .filtered_level (filtered_level)
    );

    stillness_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .accel_x        (accel_x),
        .accel_y        (accel_y),
        .accel_z        (accel_z),
        .elapsed_us     (elapsed_us),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .stopped        (stopped),
        .still_now      (still_now),
        .filtered_level (filtered_level),
        .failures       (failures),
        .outstanding    (outstanding),
        .checked        (checked)
    );

    always #4 clk = ~clk;

    // Offers one request and holds it until the block takes it.
    task automatic send_item(input logic signed [ACCEL_W-1:0] x, y, z,
                             input logic [CFG_W-1:0] dt);
        if (!steady && $urandom_range(99) < 33)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 60);
        end
        accel_x    <= x;
        accel_y    <= y;
        accel_z    <= z;
        elapsed_us <= dt;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
    endtask

    // Stops offering and waits until every predicted result has come back.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Writes all four registers, then a write to an unused index that must be ignored.
    task automatic program_filter(input filter_setting_t fs);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BIAS;
        cfg_data  <= fs.bias;
        @(posedge clk);
        cfg_index <= CFG_TAU;
        cfg_data  <= fs.tau;
        @(posedge clk);
        cfg_index <= CFG_THRESHOLD;
        cfg_data  <= fs.thresh;
        @(posedge clk);
        cfg_index <= CFG_HOLD;
        cfg_data  <= {8'($urandom), fs.hold};
        @(posedge clk);
        cfg_index <= CFG_SPARE + 3'($urandom_range(3));
        cfg_data  <= 24'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly samples near the bias magnitude on one axis, some motion, some noise.
    function automatic accel_sample_t draw_sample(input logic [CFG_W-1:0] bias);
        accel_sample_t s;
        int            comp[3];
        int            span;
        int            lead;
        int unsigned   pick;
        int unsigned   axis;
        pick = $urandom_range(99);
        axis = $urandom_range(2);
        span = (int'(bias) + 128) >>> 8;
        if (span > 32767)
            span = 32767;
        if (pick < 65)
        begin
            lead    = span + int'($urandom_range(6)) - 3;
            comp[0] = int'($urandom_range(8)) - 4;
            comp[1] = int'($urandom_range(8)) - 4;
            comp[2] = int'($urandom_range(8)) - 4;
            s.dt    = 24'($urandom_range(2000, 200));
        end
        else if (pick < 80)
        begin
            lead    = span + int'($urandom_range(3000, 50));
            comp[0] = int'($urandom_range(3000)) - 1500;
            comp[1] = int'($urandom_range(3000)) - 1500;
            comp[2] = int'($urandom_range(3000)) - 1500;
            s.dt    = 24'($urandom_range(5000, 1));
        end
        else
        begin
            s.x  = 16'($urandom);
            s.y  = 16'($urandom);
            s.z  = 16'($urandom);
            s.dt = 24'($urandom);
            return s;
        end
        if ($urandom_range(1))
            lead = -lead;
        if (lead > 32767)
            lead = 32767;
        if (lead < -32768)
            lead = -32768;
        comp[axis] = lead;
        s.x = 16'(comp[0]);
        s.y = 16'(comp[1]);
        s.z = 16'(comp[2]);
        return s;
    endfunction

    // Result side: random back-pressure, plus one long hold-off when asked.
    initial
    begin
        int held;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                for (held = 0; held < HOLD_OFF_CYCLES; held++)
                    @(posedge clk);
            end
            else
                out_ready <= steady || ($urandom_range(99) >= 33);
        end
    end

    // Guard against a hung run.
    initial
    begin
        #10ms;
        $display("Verification failed");
        $finish;
    end

    // Request and register stimulus, then the verdict.
    initial
    begin
        filter_setting_t plan[PHASES];
        accel_sample_t   s;
        int              p;
        int              n;

        plan[0] = '{BIAS_RESET, TAU_RESET, THRESHOLD_RESET, HOLD_RESET, 300};
        plan[1] = '{BIAS_RESET, 24'd2000, 24'd2048, 16'd0, 200};
        plan[2] = '{BIAS_RESET, 24'd0, 24'd512, 16'd3, 200};
        plan[3] = '{24'd0, 24'hFFFFFF, 24'hFFFFFF, 16'd10, 150};
        plan[4] = '{24'hFFFFFF, 24'd1, 24'd0, 16'hFFFF, 150};
        plan[5] = '{24'($urandom_range(300000, 200000)), 24'($urandom_range(100000, 1)),
                    24'($urandom_range(4096, 256)), 16'($urandom_range(20)), 300};
        plan[6] = '{BIAS_RESET, 24'd500, 24'd1024, 16'd65534, 150};
        plan[7] = '{24'($urandom), 24'($urandom), 24'($urandom), 16'($urandom), 200};
        plan[8] = '{BIAS_RESET, TAU_RESET, THRESHOLD_RESET, 16'd5, 280};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes under the reset settings, zero and full elapsed time.
        send_item(0, 0, 0, 0);
        send_item(-32768, -32768, -32768, 24'hFFFFFF);
        send_item(32767, 32767, 32767, 1);
        send_item(-32768, 0, 0, 0);
        send_item(0, 32767, 0, 1000);
        send_item(0, 0, -32768, 24'hFFFFFF);
        send_item(0, 0, 0, 24'hFFFFFF);
        send_item(32767, -32768, 32767, 24'h800000);

        // Gravity alone pulls the level back toward zero and into stillness.
        for (n = 0; n < 12; n++)
            send_item(0, 0, 16'((n % 2) ? 981 : -981), 24'd100000);

        // Random phases, each under its own register setting.
        for (p = 0; p < PHASES; p++)
        begin
            settle();
            program_filter(plan[p]);
            steady = (p == STEADY_PHASE);
            if (p == SQUEEZE_PHASE)
                hold_off_req = 1'b1;
            for (n = 0; n < plan[p].items; n++)
            begin
                s = draw_sample(plan[p].bias);
                send_item(s.x, s.y, s.z, s.dt);
            end
        end
        steady = 1'b0;

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests under %0d register settings, extremes included;",
                 sent, PHASES + 1);
        $display("%0d results compared, with a %0d-cycle output hold-off along the way.",
                 checked, HOLD_OFF_CYCLES);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
